// ===== rtl/rc_ppm_pwm_pulse_decoder_assert.svh =====
// assertion macros for the rc pulse decoder
`ifndef RC_PPM_PWM_PULSE_DECODER_ASSERT_SVH
`define RC_PPM_PWM_PULSE_DECODER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RCPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcpd assertion failed");

// next-cycle implication, disabled while in reset
`define RCPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcpd assertion failed");

`endif

// ===== rtl/rcpd_pkg.sv =====
// shared constants and types of the rc pulse decoder
package rcpd_pkg;

  localparam int NUM_CHANNELS  = 12;
  localparam int NUM_PWM_LINES = 8;

  localparam int TS_W       = 16;
  localparam int LINE_W     = 3;
  localparam int IDX_W      = 4;
  localparam int SLOT_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CH_IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int LN_IDX_W   = (NUM_PWM_LINES > 1) ? $clog2(NUM_PWM_LINES) : 1;

  localparam logic [TS_W-1:0]   CENTRE_WIDTH = TS_W'(3000);
  localparam logic [SLOT_W-1:0] SLOT_MAX     = SLOT_W'(15);

  localparam logic MODE_PPM  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // reset values of the setup registers
  localparam logic              RST_MODE      = MODE_PPM;
  localparam logic [SLOT_W-1:0] RST_CH_COUNT  = SLOT_W'(8);
  localparam logic [TS_W-1:0]   RST_SYNC_GAP  = TS_W'(5400);
  localparam logic [TS_W-1:0]   RST_MIN_WIDTH = TS_W'(1500);
  localparam logic [TS_W-1:0]   RST_MAX_WIDTH = TS_W'(4500);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 3'd0,
    CFG_CH_COUNT  = 3'd1,
    CFG_SYNC_GAP  = 3'd2,
    CFG_MIN_WIDTH = 3'd3,
    CFG_MAX_WIDTH = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] ppm_channel_count;
    logic [TS_W-1:0]   sync_gap;
    logic [TS_W-1:0]   min_width;
    logic [TS_W-1:0]   max_width;
  } cfg_t;

endpackage

// ===== rtl/rcpd_cfg_regs.sv =====
// setup register file of the rc pulse decoder
module rcpd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rcpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rcpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output rcpd_pkg::cfg_t                 cfg_o
);
  import rcpd_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE:      cfg_d.mode              = cfg_data_i[0];
        CFG_CH_COUNT:  cfg_d.ppm_channel_count = cfg_data_i[SLOT_W-1:0];
        CFG_SYNC_GAP:  cfg_d.sync_gap          = cfg_data_i[TS_W-1:0];
        CFG_MIN_WIDTH: cfg_d.min_width         = cfg_data_i[TS_W-1:0];
        CFG_MAX_WIDTH: cfg_d.max_width         = cfg_data_i[TS_W-1:0];
        default:       cfg_d = cfg_q; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode              <= RST_MODE;
      cfg_q.ppm_channel_count <= RST_CH_COUNT;
      cfg_q.sync_gap          <= RST_SYNC_GAP;
      cfg_q.min_width         <= RST_MIN_WIDTH;
      cfg_q.max_width         <= RST_MAX_WIDTH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/rc_ppm_pwm_pulse_decoder.sv =====
// top level of the rc ppm / pwm pulse decoder
// registers from input transfer to result transfer: input register, then result register
// throughput: one item per cycle while the result side does not stall; state update and result share a single pass
// reset: widths to 3000, slot/edge/capture state to zero, setup to defaults, no sweep
`include "rc_ppm_pwm_pulse_decoder_assert.svh"

module rc_ppm_pwm_pulse_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // setup write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rcpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rcpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input item channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic [rcpd_pkg::LINE_W-1:0]     capture_line_i,
  input  logic [rcpd_pkg::TS_W-1:0]       timestamp_i,
  input  logic [rcpd_pkg::IDX_W-1:0]      read_index_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rcpd_pkg::TS_W-1:0]       width_o,
  output logic                            stored_o,
  output logic [rcpd_pkg::IDX_W-1:0]      channel_o
);
  import rcpd_pkg::*;

  cfg_t cfg;

  rcpd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // ---------------------------------------------------------------
  // handshake: input register feeds the result register, which acts
  // as the output stage; a held result only stalls the input side
  // when the input register is also occupied
  // ---------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, advance, in_xfer;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // input register payload
  logic              s1_func_q;
  logic [LINE_W-1:0] s1_line_q;
  logic [TS_W-1:0]   s1_ts_q;
  logic [IDX_W-1:0]  s1_idx_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_func_q <= func_i;
      s1_line_q <= capture_line_i;
      s1_ts_q   <= timestamp_i;
      s1_idx_q  <= read_index_i;
    end
  end

  // ---------------------------------------------------------------
  // decoder state
  // ---------------------------------------------------------------
  logic [TS_W-1:0]   widths_q [NUM_CHANNELS];
  logic [TS_W-1:0]   widths_d [NUM_CHANNELS];
  logic [TS_W-1:0]   rise_q   [NUM_PWM_LINES];
  logic [TS_W-1:0]   rise_d   [NUM_PWM_LINES];
  logic [NUM_PWM_LINES-1:0] line_high_q, line_high_d;
  logic [TS_W-1:0]   cur_cap_q, cur_cap_d;   // last ppm capture
  logic [SLOT_W-1:0] slot_q, slot_d;         // ppm slot, saturates at SLOT_MAX

  // single-pass item logic
  logic [TS_W-1:0]     gap;
  logic [TS_W-1:0]     pwm_w;
  logic [LN_IDX_W-1:0] ln;
  logic                ppm_in_window;
  logic [TS_W-1:0]     res_width;
  logic                res_stored;
  logic [IDX_W-1:0]    res_channel;

  assign ln    = s1_line_q[LN_IDX_W-1:0];
  assign gap   = s1_ts_q - cur_cap_q;          // wraps mod 2^16
  assign pwm_w = s1_ts_q - rise_q[ln];         // wraps mod 2^16
  assign ppm_in_window = (gap > cfg.min_width) && (gap < cfg.max_width) &&
                         (slot_q < cfg.ppm_channel_count) &&
                         (32'(slot_q) < NUM_CHANNELS);

  always_comb begin
    widths_d    = widths_q;
    rise_d      = rise_q;
    line_high_d = line_high_q;
    cur_cap_d   = cur_cap_q;
    slot_d      = slot_q;
    res_width   = '0;
    res_stored  = 1'b0;
    res_channel = '0;

    if (s1_func_q == FUNC_READ) begin
      // read: out-of-range index returns zero width, echoes the index
      if (32'(s1_idx_q) < NUM_CHANNELS) begin
        res_width = widths_q[s1_idx_q[CH_IDX_W-1:0]];
      end
      res_channel = s1_idx_q;
    end else if (cfg.mode == MODE_PPM) begin
      cur_cap_d = s1_ts_q;
      if (gap > cfg.sync_gap) begin
        // frame sync: restart at slot zero
        slot_d = '0;
      end else begin
        if (ppm_in_window) begin
          widths_d[slot_q[CH_IDX_W-1:0]] = gap;
          res_width   = gap;
          res_stored  = 1'b1;
          res_channel = IDX_W'(slot_q);
        end
        if (slot_q < SLOT_MAX) begin
          slot_d = slot_q + 1'b1;
        end
      end
    end else if (32'(s1_line_q) < NUM_PWM_LINES) begin
      if (!line_high_q[ln]) begin
        // rising edge: remember the time
        rise_d[ln]      = s1_ts_q;
        line_high_d[ln] = 1'b1;
      end else begin
        // falling edge: store the pulse width if the line has a channel
        line_high_d[ln] = 1'b0;
        if (32'(s1_line_q) < NUM_CHANNELS) begin
          widths_d[CH_IDX_W'(s1_line_q)] = pwm_w;
          res_width   = pwm_w;
          res_stored  = 1'b1;
          res_channel = IDX_W'(s1_line_q);
        end
      end
    end
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        widths_q[i] <= CENTRE_WIDTH;
      end
      for (int j = 0; j < NUM_PWM_LINES; j++) begin
        rise_q[j] <= '0;
      end
      line_high_q <= '0;
      cur_cap_q   <= '0;
      slot_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        widths_q    <= widths_d;
        rise_q      <= rise_d;
        line_high_q <= line_high_d;
        cur_cap_q   <= cur_cap_d;
        slot_q      <= slot_d;
      end
    end
  end

  // result register payload
  logic [TS_W-1:0]  width_q;
  logic             stored_q;
  logic [IDX_W-1:0] channel_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      width_q   <= res_width;
      stored_q  <= res_stored;
      channel_q <= res_channel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign width_o     = width_q;
  assign stored_o    = stored_q;
  assign channel_o   = channel_q;

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  // a stored width always names a real channel
  `RCPD_ASSERT_IMPL(a_stored_channel_range, clk_i, rst_ni,
                    out_valid_q && stored_q, 32'(channel_q) < NUM_CHANNELS)
  // an item held back by a stalled result is not lost
  `RCPD_ASSERT_NEXT(a_hold_input_item, clk_i, rst_ni,
                    in_stall_o, s1_valid_q)
  // a ppm sync gap restarts the frame at slot zero
  `RCPD_ASSERT_NEXT(a_sync_resets_slot, clk_i, rst_ni,
                    advance && (s1_func_q != FUNC_READ) && (cfg.mode == MODE_PPM) &&
                    (gap > cfg.sync_gap), slot_q == '0)

endmodule

// ===== tb/tb_rc_ppm_pwm_pulse_decoder.sv =====
// self-checking testbench of the rc ppm / pwm pulse decoder with a built-in pulse width predictor
module tb_rc_ppm_pwm_pulse_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import rcpd_pkg::*;

  localparam logic FUNC_CAPTURE    = ~FUNC_READ;
  localparam logic MODE_PWM        = ~MODE_PPM;
  localparam int   IDLE_PCT        = 9;
  localparam int   SETTLE_CYCLES   = 8;
  localparam int   HOLD_CYCLES     = 64;      // long receiver hold-off
  localparam int   ITEMS_PER_PHASE = 75;
  localparam int   NUM_PHASES      = 8;
  localparam int   CYCLE_LIMIT     = 200000;

  // one input item and one result item, at the block's widths
  typedef struct packed {
    logic              func;
    logic [LINE_W-1:0] line;
    logic [TS_W-1:0]   ts;
    logic [IDX_W-1:0]  idx;
  } capture_t;

  typedef struct packed {
    logic [TS_W-1:0]  width;
    logic             stored;
    logic [IDX_W-1:0] channel;
  } pulse_t;

  // block inputs, all known from time zero
  logic                  clk          = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  func         = 1'b0;
  logic [LINE_W-1:0]     capture_line = '0;
  logic [TS_W-1:0]       timestamp    = '0;
  logic [IDX_W-1:0]      read_index   = '0;
  logic                  out_stall    = 1'b0;

  // block outputs
  logic                  cfg_ready;
  logic                  in_stall;
  logic                  out_valid;
  logic [TS_W-1:0]       width;
  logic                  stored;
  logic [IDX_W-1:0]      channel;

  // predictor state: its own copy of widths, capture history, slot and line tracking
  logic [TS_W-1:0]   ch_width [NUM_CHANNELS];
  logic [TS_W-1:0]   last_ts;
  logic [TS_W-1:0]   this_ts;
  logic [SLOT_W-1:0] slot;
  logic              line_hi [NUM_PWM_LINES];
  logic [TS_W-1:0]   rise_ts [NUM_PWM_LINES];
  cfg_t              setup;

  // pulses predicted for accepted items, oldest first
  pulse_t pending_pulses[$];

  int          errors      = 0;
  int          items_sent  = 0;
  int          cycle_count = 0;
  logic [TS_W-1:0] tick    = '0;    // last timestamp sent
  logic        quiet       = 1'b0;  // no idling on either side while set
  int          holds_asked = 0;
  int          holds_done  = 0;
  int          hold_left   = 0;

  rc_ppm_pwm_pulse_decoder u_top (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .capture_line_i (capture_line),
    .timestamp_i    (timestamp),
    .read_index_i   (read_index),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .width_o        (width),
    .stored_o       (stored),
    .channel_o      (channel)
  );

  always #6 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_rc_ppm_pwm_pulse_decoder: FAIL");
      $finish;
    end
  end

  // predicted pulse for one item; updates the predictor state like the block does
  function automatic pulse_t decode_pulse(capture_t c);
    pulse_t          r;
    logic [TS_W-1:0] gap;
    r = '0;
    if (c.func == FUNC_READ) begin
      // reads past the last channel give width zero but echo the index
      if (c.idx < NUM_CHANNELS) r.width = ch_width[c.idx];
      r.channel = c.idx;
    end else if (setup.mode == MODE_PPM) begin
      last_ts = this_ts;
      this_ts = c.ts;
      gap     = this_ts - last_ts;   // wraps modulo 2^16
      if (gap > setup.sync_gap) begin
        slot = '0;                    // frame sync, nothing stored
      end else begin
        if (gap > setup.min_width && gap < setup.max_width &&
            slot < setup.ppm_channel_count && slot < NUM_CHANNELS) begin
          ch_width[slot] = gap;
          r.width        = gap;
          r.stored       = 1'b1;
          r.channel      = IDX_W'(slot);
        end
        if (slot < SLOT_MAX) slot = slot + 1'b1;   // saturates
      end
    end else if (c.line < NUM_PWM_LINES) begin
      if (!line_hi[c.line]) begin
        // rise edge just records the time
        rise_ts[c.line] = c.ts;
        line_hi[c.line] = 1'b1;
      end else begin
        line_hi[c.line] = 1'b0;
        gap             = c.ts - rise_ts[c.line];
        if (c.line < NUM_CHANNELS) begin
          ch_width[c.line] = gap;
          r.width          = gap;
          r.stored         = 1'b1;
          r.channel        = IDX_W'(c.line);
        end
      end
    end
    return r;
  endfunction

  // receiver: random stalls, long hold-off on request, none while quiet
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_asked != holds_done) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // result checker: decides at the falling edge which result transfers at the next rising edge
  always @(negedge clk) begin
    pulse_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_pulses.size() == 0) begin
        $error("unexpected result: width %0d stored %0d channel %0d", width, stored, channel);
        errors++;
      end else begin
        want = pending_pulses.pop_front();
        if (width !== want.width) begin
          $error("width: expected %0d actual %0d", want.width, width);
          errors++;
        end
        if (stored !== want.stored) begin
          $error("stored: expected %0d actual %0d", want.stored, stored);
          errors++;
        end
        if (channel !== want.channel) begin
          $error("channel: expected %0d actual %0d", want.channel, channel);
          errors++;
        end
      end
    end
  end

  // one item transfer with random idle cycles in front; prediction at acceptance
  task automatic send_item(capture_t c);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= c.func;
    capture_line <= c.line;
    timestamp    <= c.ts;
    read_index   <= c.idx;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    pending_pulses.push_back(decode_pulse(c));
    items_sent++;
  endtask

  // capture edge; read index carries random noise since it is ignored
  task automatic capture(logic [LINE_W-1:0] line, logic [TS_W-1:0] ts);
    capture_t c;
    c.func = FUNC_CAPTURE;
    c.line = line;
    c.ts   = ts;
    c.idx  = IDX_W'($urandom_range(0, 15));
    tick   = ts;
    send_item(c);
  endtask

  // width read; line and timestamp are noise
  task automatic read_width(logic [IDX_W-1:0] idx);
    capture_t c;
    c.func = FUNC_READ;
    c.line = LINE_W'($urandom_range(0, 7));
    c.ts   = TS_W'($urandom);
    c.idx  = idx;
    send_item(c);
  endtask

  // wait until every predicted pulse has come back, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    case (idx)
      CFG_MODE:      setup.mode              = val[0];
      CFG_CH_COUNT:  setup.ppm_channel_count = val[SLOT_W-1:0];
      CFG_SYNC_GAP:  setup.sync_gap          = val;
      CFG_MIN_WIDTH: setup.min_width         = val;
      CFG_MAX_WIDTH: setup.max_width         = val;
      default: ;
    endcase
  endtask

  // all five registers, only once the block is idle
  task automatic apply_setup(cfg_t c);
    drain();
    write_reg(CFG_MODE,      CFG_DATA_W'(c.mode));
    write_reg(CFG_CH_COUNT,  CFG_DATA_W'(c.ppm_channel_count));
    write_reg(CFG_SYNC_GAP,  c.sync_gap);
    write_reg(CFG_MIN_WIDTH, c.min_width);
    write_reg(CFG_MAX_WIDTH, c.max_width);
    cfg_valid <= 1'b0;
  endtask

  // slot gap: mostly inside the window, some on its edges, some anywhere
  function automatic logic [TS_W-1:0] slot_gap();
    int roll;
    roll = $urandom_range(99);
    if (setup.min_width + 1 < setup.max_width && roll < 85)
      return TS_W'($urandom_range(setup.min_width + 1, setup.max_width - 1));
    if (roll < 92) return roll[0] ? setup.min_width : setup.max_width;
    return TS_W'($urandom);
  endfunction

  // reset widths, in-range and out-of-range reads
  task automatic test_reset_widths();
    read_width(IDX_W'(0));
    read_width(IDX_W'(NUM_CHANNELS - 1));
    read_width(IDX_W'(NUM_CHANNELS));
    read_width('1);
  endtask

  // ppm window edges, sync threshold and timer wrap under the reset setup
  task automatic test_ppm_window();
    capture(LINE_W'(0), TS_W'(0));        // zero gap from reset
    capture(LINE_W'(0), TS_W'(6000));     // sync, slot back to zero
    capture('1,         TS_W'(7501));     // just above min, line ignored
    capture(LINE_W'(0), TS_W'(12000));    // just below max
    capture(LINE_W'(0), TS_W'(13500));    // exactly min, not stored
    capture(LINE_W'(0), TS_W'(18000));    // exactly max, not stored
    capture(LINE_W'(0), TS_W'(23400));    // exactly sync gap, no sync
    capture(LINE_W'(0), '1);              // long gap, sync
    capture(LINE_W'(0), TS_W'(2999));     // gap across the timer wrap
    read_width(IDX_W'(0));
    read_width(IDX_W'(1));
  endtask

  // pwm rise/fall pairs: equal edge times and a wrap across zero
  task automatic test_pwm_lines();
    cfg_t c;
    c      = setup;
    c.mode = MODE_PWM;
    apply_setup(c);
    capture(LINE_W'(0), TS_W'(100));
    capture(LINE_W'(0), TS_W'(100));     // zero width
    capture('1, TS_W'(16'hFFF0));
    capture('1, TS_W'(16'h0010));        // wraps to 0x20
    read_width(IDX_W'(NUM_PWM_LINES - 1));
  endtask

  // mostly well-formed frames (sync then slots), the rest reads and random edges
  task automatic run_ppm_traffic(int n_items);
    int stop;
    int slots;
    int g;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      if ($urandom_range(99) < 80) begin
        if (setup.sync_gap != '1) begin
          g = int'(setup.sync_gap) + 1 + $urandom_range(0, 3000);
          if (g > 65535) g = 65535;
          capture(LINE_W'($urandom_range(0, 7)), tick + TS_W'(g));
        end
        // a few long frames run the slot counter into saturation
        slots = ($urandom_range(9) == 0) ? $urandom_range(13, 18) : $urandom_range(1, 12);
        repeat (slots) begin
          if ($urandom_range(9) == 0) read_width(IDX_W'($urandom_range(0, 15)));
          capture(LINE_W'($urandom_range(0, 7)), tick + slot_gap());
        end
      end else if ($urandom_range(1) == 0) begin
        read_width(IDX_W'($urandom_range(0, 15)));
      end else begin
        capture(LINE_W'($urandom_range(0, 7)), TS_W'($urandom));
      end
    end
  endtask

  // interleaved lines, each alternating rise and fall
  task automatic run_pwm_traffic(int n_items);
    int stop;
    int roll;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      roll = $urandom_range(99);
      if (roll < 10)
        read_width(IDX_W'($urandom_range(0, 15)));
      else if (roll < 15)
        capture(LINE_W'($urandom_range(0, 7)), TS_W'($urandom));
      else
        capture(LINE_W'($urandom_range(0, NUM_PWM_LINES - 1)),
                tick + TS_W'($urandom_range(0, 2500)));
    end
  endtask

  // random phases: extreme setups first, then random ones; one quiet phase, two hold-offs
  task automatic test_random_traffic();
    cfg_t c;
    for (int p = 0; p < NUM_PHASES; p++) begin
      c.mode              = 1'($urandom_range(0, 1));
      c.ppm_channel_count = SLOT_W'($urandom_range(0, NUM_CHANNELS));
      c.sync_gap          = TS_W'($urandom_range(3000, 9000));
      c.min_width         = TS_W'($urandom_range(500, 2000));
      c.max_width         = TS_W'($urandom_range(2500, 6000));
      case (p)
        // never syncs, everything in the window: slots run up and saturate
        0: c = '{mode: MODE_PPM, ppm_channel_count: SLOT_W'(NUM_CHANNELS),
                 sync_gap: '1, min_width: '0, max_width: '1};
        // every nonzero gap syncs, nothing ever stored
        1: c = '{mode: MODE_PPM, ppm_channel_count: '0,
                 sync_gap: '0, min_width: '1, max_width: '0};
        2: c.mode = MODE_PWM;
        3: c.mode = MODE_PPM;
        default: ;
      endcase
      apply_setup(c);
      quiet <= (p == 4);
      if (p == 2 || p == 5) holds_asked <= holds_asked + 1;
      if (setup.mode == MODE_PPM) run_ppm_traffic(ITEMS_PER_PHASE);
      else run_pwm_traffic(ITEMS_PER_PHASE);
    end
    quiet <= 1'b0;
  endtask

  initial begin
    // predictor reset state
    foreach (ch_width[i]) ch_width[i] = CENTRE_WIDTH;
    foreach (line_hi[i]) begin
      line_hi[i] = 1'b0;
      rise_ts[i] = '0;
    end
    last_ts = '0;
    this_ts = '0;
    slot    = '0;
    setup   = '{mode: RST_MODE, ppm_channel_count: RST_CH_COUNT, sync_gap: RST_SYNC_GAP,
                min_width: RST_MIN_WIDTH, max_width: RST_MAX_WIDTH};

    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_reset_widths();
    test_ppm_window();
    test_pwm_lines();
    test_random_traffic();

    drain();
    if (errors == 0) begin
      $display("tb_rc_ppm_pwm_pulse_decoder: PASS");
    end else begin
      $display("tb_rc_ppm_pwm_pulse_decoder: FAIL");
    end
    $finish;
  end

endmodule
